@@ src/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP responder and its address cache.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int CACHE_ENTRIES_DEF = 4;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int LEN_W  = 11;
    localparam int ACT_W  = 3;
    localparam int SLOT_W = 2;
    localparam int CFG_ADDR_W = 2;

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_IP      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_MAC     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GATEWAY_IP  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUBNET_MASK = 2'd3;

    localparam logic [IP_W-1:0] SUBNET_MASK_RST = 32'hFFFF_FF00;

    // ARP header checks
    localparam logic [LEN_W-1:0] ARP_MIN_LEN    = 11'd28;
    localparam logic [15:0]      ARP_HTYPE_ETH  = 16'h0001;
    localparam logic [15:0]      ARP_PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]       ARP_HLEN       = 8'd6;
    localparam logic [7:0]       ARP_PLEN       = 8'd4;
    localparam logic [15:0]      ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0]      ARP_OP_REPLY   = 16'd2;

    // mode codes
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REPLY   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GW      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ADDED   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UPDATED = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REQUEST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_ANSWER  = 3'd6;

    typedef struct packed {
        logic             mode;
        logic [LEN_W-1:0] packet_len;
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [7:0]       hw_size;
        logic [7:0]       proto_size;
        logic [15:0]      opcode;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
        logic [IP_W-1:0]  lookup_ip;
    } arpc_req_t;

    typedef struct packed {
        logic              handled;
        logic [ACT_W-1:0]  action;
        logic [MAC_W-1:0]  peer_mac;
        logic [IP_W-1:0]   peer_ip;
        logic              found;
        logic [MAC_W-1:0]  resolved_mac;
        logic [SLOT_W-1:0] slot;
    } arpc_res_t;

    typedef struct packed {
        logic [IP_W-1:0] own_ip;
        logic [IP_W-1:0] gateway_ip;
        logic [IP_W-1:0] subnet_mask;
    } arpc_cfg_t;

endpackage

`default_nettype wire

@@ src/arpc_cache.sv @@
// ----------------------------------------------------------------------------
// arpc_cache
// IP/MAC cache memory, one read and one write port, registered read data.
// Entries that were never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_cache #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
    parameter int IDX_W         = 2
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       rd_en,
    input  wire logic [IDX_W-1:0]           rd_addr,
    output logic [arpc_pkg::IP_W-1:0]       rd_ip,
    output logic [arpc_pkg::MAC_W-1:0]      rd_mac,
    input  wire logic                       wr_en,
    input  wire logic [IDX_W-1:0]           wr_addr,
    input  wire logic [arpc_pkg::IP_W-1:0]  wr_ip,
    input  wire logic [arpc_pkg::MAC_W-1:0] wr_mac
);
    import arpc_pkg::*;

    logic [IP_W-1:0]          ip_mem  [CACHE_ENTRIES];
    logic [MAC_W-1:0]         mac_mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic [IP_W-1:0]          rd_ip_reg;
    logic [MAC_W-1:0]         rd_mac_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ip_mem[wr_addr]  <= wr_ip;
            mac_mem[wr_addr] <= wr_mac;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_ip_reg  <= valid_reg[rd_addr] ? ip_mem[rd_addr]  : '0;
            rd_mac_reg <= valid_reg[rd_addr] ? mac_mem[rd_addr] : '0;
        end
    end

    assign rd_ip  = rd_ip_reg;
    assign rd_mac = rd_mac_reg;

endmodule

`default_nettype wire

@@ src/arpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: decodes one request, walks the cache one entry per read/compare
// pair through a single IP comparator, and builds the result record.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
    parameter int IDX_W         = 2
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire arpc_pkg::arpc_cfg_t        cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire arpc_pkg::arpc_req_t        in_req,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output arpc_pkg::arpc_res_t             res,
    output logic                            rd_en,
    output logic [IDX_W-1:0]                rd_addr,
    input  wire logic [arpc_pkg::IP_W-1:0]  rd_ip,
    input  wire logic [arpc_pkg::MAC_W-1:0] rd_mac,
    output logic                            wr_en,
    output logic [IDX_W-1:0]                wr_addr,
    output logic [arpc_pkg::IP_W-1:0]       wr_ip,
    output logic [arpc_pkg::MAC_W-1:0]      wr_mac
);
    import arpc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] next_slot_reg, next_slot_next;
    logic [MAC_W-1:0] gw_mac_reg, gw_mac_next;
    logic             gw_vld_reg, gw_vld_next;
    arpc_req_t        req_reg, req_next;
    arpc_res_t        res_reg, res_next;

    logic            pkt_ok;
    logic            for_us;
    logic            on_net;
    logic            hit;
    logic [IP_W-1:0] key;

    assign pkt_ok = (req_reg.packet_len >= ARP_MIN_LEN) && (req_reg.hw_type == ARP_HTYPE_ETH)
                 && (req_reg.proto_type == ARP_PTYPE_IPV4) && (req_reg.hw_size == ARP_HLEN)
                 && (req_reg.proto_size == ARP_PLEN);
    assign for_us = pkt_ok && (req_reg.target_ip == cfg.own_ip);
    assign on_net = (req_reg.lookup_ip & cfg.subnet_mask) == (cfg.own_ip & cfg.subnet_mask);
    assign key    = (req_reg.mode == MODE_LOOKUP) ? req_reg.lookup_ip : req_reg.sender_ip;
    assign hit    = (rd_ip == key);

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        next_slot_next = next_slot_reg;
        gw_mac_next    = gw_mac_reg;
        gw_vld_next    = gw_vld_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = hit ? idx_reg : next_slot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    req_next   = in_req;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_next   = '0;
                idx_next   = '0;
                state_next = ST_DONE;
                if (req_reg.mode == MODE_PACKET) begin
                    if (for_us && req_reg.opcode == ARP_OP_REQUEST) begin
                        res_next.handled  = 1'b1;
                        res_next.action   = ACT_REPLY;
                        res_next.peer_mac = req_reg.sender_mac;
                        res_next.peer_ip  = req_reg.sender_ip;
                    end else if (for_us && req_reg.opcode == ARP_OP_REPLY) begin
                        res_next.handled = 1'b1;
                        if (req_reg.sender_ip == cfg.gateway_ip) begin
                            gw_mac_next     = req_reg.sender_mac;
                            gw_vld_next     = 1'b1;
                            res_next.action = ACT_GW;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                end else if (req_reg.lookup_ip == cfg.gateway_ip || !on_net) begin
                    res_next.action       = ACT_ANSWER;
                    res_next.found        = gw_vld_reg;
                    res_next.resolved_mac = gw_vld_reg ? gw_mac_reg : '0;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (hit || idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                    if (req_reg.mode == MODE_PACKET) begin
                        wr_en = 1'b1;
                        if (hit) begin
                            res_next.action = ACT_UPDATED;
                            res_next.slot   = SLOT_W'(idx_reg);
                        end else begin
                            res_next.action = ACT_ADDED;
                            res_next.slot   = SLOT_W'(next_slot_reg);
                            next_slot_next  = (next_slot_reg == LAST_IDX) ? '0
                                            : next_slot_reg + IDX_W'(1);
                        end
                    end else if (hit) begin
                        res_next.action       = ACT_ANSWER;
                        res_next.found        = 1'b1;
                        res_next.resolved_mac = rd_mac;
                    end else begin
                        res_next.action  = ACT_REQUEST;
                        res_next.peer_ip = req_reg.lookup_ip;
                    end
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_slot_reg <= '0;
            gw_mac_reg    <= '0;
            gw_vld_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_slot_reg <= next_slot_next;
            gw_mac_reg    <= gw_mac_next;
            gw_vld_reg    <= gw_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;
    assign rd_en     = (state_reg == ST_READ);
    assign rd_addr   = idx_reg;
    assign wr_ip     = key;
    assign wr_mac    = req_reg.sender_mac;

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> state_reg == ST_EVAL)
        else $error("accepted request did not enter decode");

    a_write_result: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> res_reg.handled && (res_reg.action == ACT_ADDED
                                      || res_reg.action == ACT_UPDATED))
        else $error("cache write without add/update result");

    a_found_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_reg.found |-> res_reg.action == ACT_ANSWER)
        else $error("found set on non-answer result");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        next_slot_reg <= LAST_IDX)
        else $error("round robin pointer out of range");

    a_idx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> $stable(idx_reg))
        else $error("search index moved during read");

endmodule

`default_nettype wire

@@ src/arp_responder_with_cache.sv @@
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// ARP request/reply handling and IP-to-MAC resolution with a round robin cache.
// ----------------------------------------------------------------------------
// One request at a time. The decode cycle after acceptance either finishes the
// result or starts a cache search. A search visits k entries (1 to
// CACHE_ENTRIES, stopping at the first hit), and each entry takes a memory
// read state and then a compare state in the shared IP comparator. The result
// passes from the sequencer's done state into the output register that drives
// m_tvalid. s_tready rises in the same cycle as m_tvalid, and no new request
// is taken before the previous one has reached the output register. While the
// output register holds a result and m_tready is low, the next finished result
// waits in the sequencer and no further request is taken. The cache needs no
// clearing after reset; entries never written read as zero.
`default_nettype none

module arp_responder_with_cache #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [arpc_pkg::CFG_ADDR_W-1:0] cfg_wr_addr,
    input  wire logic [arpc_pkg::MAC_W-1:0]      cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // packet_len, hw_type, proto_type, hw_size, proto_size, opcode,
    // sender_mac, sender_ip, target_ip, lookup_ip, zero pad
    input  wire logic [223:0]                    s_tdata,
    // mode
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // handled, peer_mac, peer_ip, found, resolved_mac, slot, zero pad
    output logic [135:0]                         m_tdata,
    // action
    output logic [arpc_pkg::ACT_W-1:0]           m_tuser
);
    import arpc_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [IP_W-1:0] own_ip_reg;
    logic [IP_W-1:0] gateway_ip_reg;
    logic [IP_W-1:0] subnet_mask_reg;
    arpc_cfg_t       cfg;
    arpc_req_t       in_req;
    arpc_res_t       res;
    arpc_res_t       out_reg;
    logic            m_tvalid_reg;
    logic            res_valid;
    logic            res_ready;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IP_W-1:0]  rd_ip;
    logic [MAC_W-1:0] rd_mac;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IP_W-1:0]  wr_ip;
    logic [MAC_W-1:0] wr_mac;

    // own MAC only feeds frame building, which sits outside this block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg      <= '0;
            gateway_ip_reg  <= '0;
            subnet_mask_reg <= SUBNET_MASK_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                CFG_OWN_IP:      own_ip_reg      <= cfg_wr_data[IP_W-1:0];
                CFG_OWN_MAC:     ;
                CFG_GATEWAY_IP:  gateway_ip_reg  <= cfg_wr_data[IP_W-1:0];
                CFG_SUBNET_MASK: subnet_mask_reg <= cfg_wr_data[IP_W-1:0];
            endcase
        end
    end

    assign cfg.own_ip      = own_ip_reg;
    assign cfg.gateway_ip  = gateway_ip_reg;
    assign cfg.subnet_mask = subnet_mask_reg;

    assign in_req.mode       = s_tuser;
    assign in_req.packet_len = s_tdata[10:0];
    assign in_req.hw_type    = s_tdata[26:11];
    assign in_req.proto_type = s_tdata[42:27];
    assign in_req.hw_size    = s_tdata[50:43];
    assign in_req.proto_size = s_tdata[58:51];
    assign in_req.opcode     = s_tdata[74:59];
    assign in_req.sender_mac = s_tdata[122:75];
    assign in_req.sender_ip  = s_tdata[154:123];
    assign in_req.target_ip  = s_tdata[186:155];
    assign in_req.lookup_ip  = s_tdata[218:187];

    arpc_ctrl #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_ip     (rd_ip),
        .rd_mac    (rd_mac),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_ip     (wr_ip),
        .wr_mac    (wr_mac)
    );

    arpc_cache #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_ip   (rd_ip),
        .rd_mac  (rd_mac),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_ip   (wr_ip),
        .wr_mac  (wr_mac)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.action;
    assign m_tdata  = {4'b0000, out_reg.slot, out_reg.resolved_mac, out_reg.found,
                       out_reg.peer_ip, out_reg.peer_mac, out_reg.handled};

endmodule

`default_nettype wire

@@ tb/arp_responder_with_cache_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_responder_with_cache_checker
// Watches the config port and both streams of the ARP responder. Each accepted
// request is run through a local model of the header checks, the gateway MAC
// store and the round robin cache. Each result is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_checker
    import arpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_wr_addr,
    input  logic [MAC_W-1:0]      cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [223:0]          s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [135:0]          m_tdata,
    input  logic [ACT_W-1:0]      m_tuser,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int CACHE_N = CACHE_ENTRIES_DEF;

    logic [IP_W-1:0]  own_ip_q;
    logic [MAC_W-1:0] own_mac_q;
    logic [IP_W-1:0]  gw_ip_q;
    logic [IP_W-1:0]  mask_q;

    logic [IP_W-1:0]  cache_ip  [CACHE_N];
    logic [MAC_W-1:0] cache_mac [CACHE_N];
    int               rr_slot;
    logic [MAC_W-1:0] gw_mac;
    logic             gw_known;

    arpc_res_t pending_outcomes[$];

    function automatic int find_slot(input logic [IP_W-1:0] ip);
        for (int k = 0; k < CACHE_N; k++) begin
            if (cache_ip[k] == ip) return k;
        end
        return -1;
    endfunction

    // updates cache and gateway state as the block would
    function automatic arpc_res_t arp_outcome(input arpc_req_t r);
        arpc_res_t o;
        logic      hdr_ok;
        int        hit;
        o = '0;
        if (r.mode == MODE_PACKET) begin
            hdr_ok = r.packet_len >= ARP_MIN_LEN && r.hw_type == ARP_HTYPE_ETH &&
                     r.proto_type == ARP_PTYPE_IPV4 && r.hw_size == ARP_HLEN &&
                     r.proto_size == ARP_PLEN;
            if (hdr_ok && r.target_ip == own_ip_q && r.opcode == ARP_OP_REQUEST) begin
                o.handled  = 1'b1;
                o.action   = ACT_REPLY;
                o.peer_mac = r.sender_mac;
                o.peer_ip  = r.sender_ip;
            end else if (hdr_ok && r.target_ip == own_ip_q && r.opcode == ARP_OP_REPLY) begin
                o.handled = 1'b1;
                if (r.sender_ip == gw_ip_q) begin
                    gw_mac   = r.sender_mac;
                    gw_known = 1'b1;
                    o.action = ACT_GW;
                end else begin
                    hit = find_slot(r.sender_ip);
                    if (hit < 0) begin
                        hit            = rr_slot;
                        cache_ip[hit]  = r.sender_ip;
                        cache_mac[hit] = r.sender_mac;
                        rr_slot        = (rr_slot + 1) % CACHE_N;
                        o.action       = ACT_ADDED;
                    end else begin
                        cache_mac[hit] = r.sender_mac;
                        o.action       = ACT_UPDATED;
                    end
                    o.slot = hit[SLOT_W-1:0];
                end
            end
        end else begin
            if (r.lookup_ip == gw_ip_q ||
                (r.lookup_ip & mask_q) != (own_ip_q & mask_q)) begin
                o.action = ACT_ANSWER;
                if (gw_known) begin
                    o.found        = 1'b1;
                    o.resolved_mac = gw_mac;
                end
            end else begin
                hit = find_slot(r.lookup_ip);
                if (hit < 0) begin
                    o.action  = ACT_REQUEST;
                    o.peer_ip = r.lookup_ip;
                end else begin
                    o.action       = ACT_ANSWER;
                    o.found        = 1'b1;
                    o.resolved_mac = cache_mac[hit];
                end
            end
        end
        return o;
    endfunction

    task automatic check_field(input string name, input logic [MAC_W-1:0] want,
                               input logic [MAC_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        arpc_req_t req;
        arpc_res_t got;
        arpc_res_t want;
        if (!aresetn) begin
            own_ip_q  = '0;
            own_mac_q = '0;
            gw_ip_q   = '0;
            mask_q    = SUBNET_MASK_RST;
            for (int k = 0; k < CACHE_N; k++) begin
                cache_ip[k]  = '0;
                cache_mac[k] = '0;
            end
            rr_slot  = 0;
            gw_mac   = '0;
            gw_known = 1'b0;
            pending_outcomes.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.handled      = m_tdata[0];
                got.peer_mac     = m_tdata[48:1];
                got.peer_ip      = m_tdata[80:49];
                got.found        = m_tdata[81];
                got.resolved_mac = m_tdata[129:82];
                got.slot         = m_tdata[131:130];
                got.action       = m_tuser;
                if (pending_outcomes.size() == 0) begin
                    $error("result with no request pending: action %0d", got.action);
                    mismatches++;
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("handled", MAC_W'(want.handled), MAC_W'(got.handled));
                    check_field("action", MAC_W'(want.action), MAC_W'(got.action));
                    check_field("peer_mac", want.peer_mac, got.peer_mac);
                    check_field("peer_ip", MAC_W'(want.peer_ip), MAC_W'(got.peer_ip));
                    check_field("found", MAC_W'(want.found), MAC_W'(got.found));
                    check_field("resolved_mac", want.resolved_mac, got.resolved_mac);
                    check_field("slot", MAC_W'(want.slot), MAC_W'(got.slot));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    CFG_OWN_IP:      own_ip_q  = cfg_wr_data[IP_W-1:0];
                    CFG_OWN_MAC:     own_mac_q = cfg_wr_data;
                    CFG_GATEWAY_IP:  gw_ip_q   = cfg_wr_data[IP_W-1:0];
                    CFG_SUBNET_MASK: mask_q    = cfg_wr_data[IP_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                req.mode       = s_tuser;
                req.packet_len = s_tdata[10:0];
                req.hw_type    = s_tdata[26:11];
                req.proto_type = s_tdata[42:27];
                req.hw_size    = s_tdata[50:43];
                req.proto_size = s_tdata[58:51];
                req.opcode     = s_tdata[74:59];
                req.sender_mac = s_tdata[122:75];
                req.sender_ip  = s_tdata[154:123];
                req.target_ip  = s_tdata[186:155];
                req.lookup_ip  = s_tdata[218:187];
                pending_outcomes.push_back(arp_outcome(req));
            end
            outstanding = pending_outcomes.size();
        end
    end

endmodule

@@ tb/arp_responder_with_cache_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_responder_with_cache_tb
// Drives ARP packets and address lookups into the responder: a directed set
// covering header checks, opcodes, gateway learning, cache add/update, empty
// slot matches and misses, then random traffic over several configurations
// with random stalls on both streams. The checker module does the compare.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_tb;
    import arpc_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 100;
    localparam int RAND_PHASES = 8;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_wr_addr;
    logic [MAC_W-1:0]      cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [223:0]          s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [135:0]          m_tdata;
    logic [ACT_W-1:0]      m_tuser;
    int                    mismatches;
    int                    outstanding;

    logic                  s_acc;
    bit                    idle_on;
    int                    idle_cycles;

    logic [IP_W-1:0]       own_ip;
    logic [MAC_W-1:0]      own_mac;
    logic [IP_W-1:0]       gw_ip;
    logic [IP_W-1:0]       mask;
    logic [IP_W-1:0]       ip_pool [8];

    arp_responder_with_cache u_dut (.*);

    arp_responder_with_cache_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) s_acc <= s_tvalid && s_tready;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("arp_responder_with_cache: mismatch");
                $finish;
            end
        end
    end

    // result side backpressure
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        m_tready <= 1'b1;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    function automatic arpc_req_t arp_packet(input logic [LEN_W-1:0] len,
                                             input logic [15:0] op,
                                             input logic [MAC_W-1:0] smac,
                                             input logic [IP_W-1:0] sip,
                                             input logic [IP_W-1:0] tip);
        arpc_req_t r;
        r            = '0;
        r.mode       = MODE_PACKET;
        r.packet_len = len;
        r.hw_type    = ARP_HTYPE_ETH;
        r.proto_type = ARP_PTYPE_IPV4;
        r.hw_size    = ARP_HLEN;
        r.proto_size = ARP_PLEN;
        r.opcode     = op;
        r.sender_mac = smac;
        r.sender_ip  = sip;
        r.target_ip  = tip;
        return r;
    endfunction

    function automatic arpc_req_t lookup_of(input logic [IP_W-1:0] ip);
        arpc_req_t r;
        r           = '0;
        r.mode      = MODE_LOOKUP;
        r.lookup_ip = ip;
        return r;
    endfunction

    // mostly well-formed traffic aimed at us from a small address pool
    function automatic arpc_req_t random_request();
        arpc_req_t    r;
        logic [223:0] noise;
        int           pick;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r     = noise[$bits(arpc_req_t)-1:0];
        pick  = $urandom_range(0, 99);
        if (pick >= 40 && pick < 80) begin
            r.mode = MODE_LOOKUP;
            if ($urandom_range(0, 4) != 0) r.lookup_ip = ip_pool[$urandom_range(0, 7)];
        end else if (pick < 92) begin
            r.mode       = MODE_PACKET;
            r.packet_len = ($urandom_range(0, 3) == 0) ? ARP_MIN_LEN
                                                       : LEN_W'($urandom_range(28, 2047));
            r.hw_type    = ARP_HTYPE_ETH;
            r.proto_type = ARP_PTYPE_IPV4;
            r.hw_size    = ARP_HLEN;
            r.proto_size = ARP_PLEN;
            r.opcode     = ($urandom_range(0, 9) < 6) ? ARP_OP_REPLY : ARP_OP_REQUEST;
            r.sender_ip  = ip_pool[$urandom_range(0, 7)];
            if ($urandom_range(0, 9) != 0) r.target_ip = own_ip;
            if (pick >= 80) begin
                case ($urandom_range(0, 5))
                    0: r.packet_len = LEN_W'($urandom_range(0, 27));
                    1: r.hw_type    = ARP_HTYPE_ETH ^ (16'h1 << $urandom_range(0, 15));
                    2: r.proto_type = ARP_PTYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15));
                    3: r.hw_size    = ARP_HLEN ^ (8'h1 << $urandom_range(0, 7));
                    4: r.proto_size = ARP_PLEN ^ (8'h1 << $urandom_range(0, 7));
                    default: r.opcode = 16'($urandom);
                endcase
            end
        end
        return r;
    endfunction

    task automatic send_req(input arpc_req_t r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= {5'b0, r.lookup_ip, r.target_ip, r.sender_ip, r.sender_mac, r.opcode,
                     r.proto_size, r.hw_size, r.proto_type, r.hw_type, r.packet_len};
        do @(negedge aclk); while (!s_acc);
    endtask

    // hold off until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [MAC_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= addr;
        cfg_wr_data <= data;
        @(negedge aclk);
    endtask

    task automatic start_phase(input int ph);
        case (ph)
            0: begin
                own_ip = 32'h0000_0005; own_mac = 48'h0200_0000_0005;
                gw_ip  = 32'h0000_0001; mask    = 32'hFFFF_FF00;
            end
            1: begin
                own_ip = 32'h0A01_0203; own_mac = 48'h0212_3456_789A;
                gw_ip  = 32'h0A01_02FE; mask    = 32'hFFFF_FF00;
            end
            2: begin
                own_ip = 32'hC0A8_0064; own_mac = 48'h02AB_CDEF_0123;
                gw_ip  = 32'hC0A8_0001; mask    = 32'h0000_0000;
            end
            3: begin
                own_ip = 32'h0000_0000; own_mac = 48'h0;
                gw_ip  = 32'hFFFF_FFFF; mask    = 32'hFFFF_FFFF;
            end
            4: begin
                own_ip = 32'hFFFF_FFFF; own_mac = 48'hFFFF_FFFF_FFFF;
                gw_ip  = 32'hFFFF_FFFE; mask    = 32'hFFFF_0000;
            end
            default: begin
                own_ip  = $urandom;
                own_mac = {16'($urandom), $urandom};
                mask    = 32'hFFFF_FFFF << $urandom_range(0, 32);
                gw_ip   = (own_ip & mask) | ($urandom & ~mask);
            end
        endcase
        cfg_write(CFG_OWN_IP, MAC_W'(own_ip));
        cfg_write(CFG_OWN_MAC, own_mac);
        cfg_write(CFG_GATEWAY_IP, MAC_W'(gw_ip));
        cfg_write(CFG_SUBNET_MASK, MAC_W'(mask));
        cfg_wr_en <= 1'b0;
        ip_pool[0] = gw_ip;
        ip_pool[1] = '0;
        for (int k = 2; k < 6; k++) ip_pool[k] = (own_ip & mask) | ($urandom & ~mask);
        ip_pool[6] = own_ip;
        ip_pool[7] = $urandom;
    endtask

    initial begin
        arpc_req_t pkt;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_addr = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_PACKET;
        idle_on     = 1'b1;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset configuration: own and gateway IP both zero
        send_req(lookup_of(32'h0));
        send_req(lookup_of(32'hC0A8_0001));
        send_req(arp_packet(11'd28, ARP_OP_REQUEST, 48'h0000_0000_0001, 32'h0A00_0002, 32'h0));
        settle();

        start_phase(0);
        send_req(lookup_of(32'h0));                 // empty slot matches 0.0.0.0
        send_req(lookup_of(32'h0000_0001));         // gateway, MAC unknown
        send_req(lookup_of(32'hC0A8_0101));         // off subnet, MAC unknown
        send_req(arp_packet(11'd28, ARP_OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, own_ip));
        send_req(arp_packet(11'd2047, ARP_OP_REPLY, 48'h0000_5E00_0001, gw_ip, own_ip));
        send_req(lookup_of(32'hC0A8_0101));
        send_req(lookup_of(32'h0000_0001));
        send_req(arp_packet(11'd60, ARP_OP_REPLY, 48'hAAAA_AAAA_AAAA, 32'h10, own_ip));
        send_req(arp_packet(11'd60, ARP_OP_REPLY, 48'h5555_5555_5555, 32'h10, own_ip));
        send_req(arp_packet(11'd28, ARP_OP_REPLY, 48'h1234_5678_9ABC, 32'h0, own_ip));
        send_req(lookup_of(32'h10));
        send_req(lookup_of(32'h22));                // miss: request
        for (int k = 0; k < 9; k++) begin
            pkt = arp_packet(11'd28, ARP_OP_REQUEST, 48'h0200_0000_0010, 32'h10, own_ip);
            case (k)
                0: pkt.packet_len = 11'd27;
                1: pkt.hw_type    = 16'h0002;
                2: pkt.proto_type = 16'h86DD;
                3: pkt.hw_size    = 8'd5;
                4: pkt.proto_size = 8'hFF;
                5: pkt.opcode     = 16'd3;
                6: pkt.opcode     = 16'd0;
                7: pkt.opcode     = 16'hFFFF;
                default: pkt.target_ip = 32'h0000_0006;
            endcase
            send_req(pkt);
        end
        settle();

        for (int ph = 1; ph <= RAND_PHASES; ph++) begin
            start_phase(ph);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_on = (ph < RAND_PHASES - 1) && ((n / 40) % 3 != 2);
                send_req(random_request());
            end
            settle();
        end
        repeat (20) @(negedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("arp_responder_with_cache: match");
        end else begin
            $display("arp_responder_with_cache: mismatch");
        end
        $finish;
    end

endmodule
